// ===== design/psu_pkg.sv =====
package psu_pkg;

    localparam int MAX_PARTICLES = 64;
    localparam int ADDR_W        = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
    localparam int FACTOR_W      = 17;
    localparam int CFG_IDX_W     = 2;

    localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'h10000;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_SHIFT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] arg_x;
        logic signed [31:0] arg_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic [31:0]        begin_color;
        logic [31:0]        end_color;
        logic [15:0]        begin_size;
        logic [15:0]        end_size;
        logic [31:0]        time_value;
    } item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic [15:0]        out_size;
        logic [31:0]        out_color;
        logic               last;
    } result_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic [31:0]        begin_color;
        logic [31:0]        end_color;
        logic [15:0]        begin_size;
        logic [15:0]        end_size;
        logic [31:0]        birth;
        logic [31:0]        life;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                     input logic signed [47:0] b);
        logic signed [48:0] s;
        s = $signed({{17{a[31]}}, a}) + $signed({b[47], b});
        if (s > 49'sh0_0000_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (s < -49'sh0_0000_8000_0000)
            return 32'sh8000_0000;
        else
            return s[31:0];
    endfunction

    function automatic logic signed [47:0] sext48(input logic signed [31:0] a);
        return {{16{a[31]}}, a};
    endfunction

endpackage

// ===== design/psu_ram.sv =====
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/psu_div.sv =====
module psu_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [31:0]                   elapsed,
    input  logic [31:0]                   life,
    output logic                          done,
    output logic [psu_pkg::FACTOR_W-1:0]  factor
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] div_reg, div_next;
    logic [15:0] quo_reg, quo_next;
    logic [psu_pkg::FACTOR_W-1:0] factor_reg, factor_next;
    logic [32:0] rem2;
    logic        qbit;

    // restoring division, one quotient bit per cycle; rem stays below the divisor
    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        quo_next    = quo_reg;
        factor_next = factor_reg;
        rem2        = {rem_reg, 1'b0};
        qbit        = (rem2 >= {1'b0, div_reg});
        if (start)
        begin
            if (life == 32'd0 || elapsed >= life)
            begin
                factor_next = psu_pkg::FACTOR_ONE;
                done_next   = 1'b1;
            end
            else
            begin
                rem_next  = elapsed;
                div_next  = life;
                cnt_next  = 5'd16;
                quo_next  = 16'd0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (qbit)
            begin
                rem_next = 32'(rem2 - {1'b0, div_reg});
            end
            else
            begin
                rem_next = rem2[31:0];
            end
            quo_next = {quo_reg[14:0], qbit};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next   = 1'b0;
                done_next   = 1'b1;
                factor_next = {1'b0, quo_reg[14:0], qbit};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        quo_reg    <= quo_next;
        factor_reg <= factor_next;
    end

    assign done   = done_reg;
    assign factor = factor_reg;

endmodule

// ===== design/psu_blend.sv =====
module psu_blend (
    input  psu_pkg::entry_t               ent,
    input  logic [psu_pkg::FACTOR_W-1:0]  factor,
    output logic [31:0]                   color,
    output logic [15:0]                   size
);

    // b*(1-f) + e*f == b + (e-b)*f, floored by the arithmetic shift
    always_comb
    begin
        logic signed [8:0]  d8;
        logic signed [26:0] p8;
        logic signed [16:0] d16;
        logic signed [34:0] p16;
        color = 32'd0;
        for (int ch = 0; ch < 4; ch++)
        begin
            d8 = $signed({1'b0, ent.end_color[8*ch +: 8]})
               - $signed({1'b0, ent.begin_color[8*ch +: 8]});
            p8 = d8 * $signed({1'b0, factor});
            color[8*ch +: 8] = ent.begin_color[8*ch +: 8] + p8[23:16];
        end
        d16  = $signed({1'b0, ent.end_size}) - $signed({1'b0, ent.begin_size});
        p16  = d16 * $signed({1'b0, factor});
        size = ent.begin_size + p16[31:16];
    end

endmodule

// ===== design/particle_store_euler_update.sv =====
// channel | direction | handshake                  | word
// item    | in        | item_valid / item_ready    | psu_pkg::item_t
// result  | out       | result_valid / result_ready| psu_pkg::result_t
// cfg     | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One item at a time; an add is written as it is accepted, a shift reads, loads
// and writes back each particle. A tick walks the store three times through the
// entry RAM: motion (one shared 33x33 multiplier), expiry (moving the last
// entry down over an expired one), emit (waiting on the 16-step divider).
// Reset clears counts, time and origin; the entry RAM is not cleared.
// A stalled result word holds the emit walk; items wait while work runs.
module particle_store_euler_update (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  psu_pkg::item_t                     item,
    output logic                               result_valid,
    input  logic                               result_ready,
    output psu_pkg::result_t                   result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [psu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                        cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_LD   = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_WR   = 4'd4;
    localparam logic [3:0] S_MVRD = 4'd5;
    localparam logic [3:0] S_MVWR = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    localparam logic [1:0] PH_SHIFT  = 2'd0;
    localparam logic [1:0] PH_MOVE   = 2'd1;
    localparam logic [1:0] PH_EXPIRE = 2'd2;
    localparam logic [1:0] PH_EMIT   = 2'd3;

    localparam int AW = psu_pkg::ADDR_W;
    localparam int CW = psu_pkg::CNT_W;

    logic [3:0]         state_reg, state_next;
    logic [1:0]         ph_reg, ph_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      live_reg, live_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic signed [31:0] origin_x_reg, origin_x_next;
    logic signed [31:0] origin_y_reg, origin_y_next;
    logic [31:0]        prev_time_reg, prev_time_next;
    logic               seen_reg, seen_next;
    logic [31:0]        tv_reg, tv_next;
    logic [31:0]        dt_reg, dt_next;
    logic signed [31:0] arg_x_reg, arg_x_next;
    logic signed [31:0] arg_y_reg, arg_y_next;
    psu_pkg::entry_t    ent_reg, ent_next;
    logic signed [47:0] mul_reg, mul_next;
    psu_pkg::result_t   result_reg, result_next;
    logic               result_valid_reg, result_valid_next;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    psu_pkg::entry_t      mem_wdata, mem_rdata;
    logic                 div_start, div_done;
    logic [31:0]          div_elapsed;
    logic [psu_pkg::FACTOR_W-1:0] factor;
    logic [31:0]          bl_color;
    logic [15:0]          bl_size;

    psu_ram #(
        .WIDTH(psu_pkg::ENTRY_W),
        .DEPTH(psu_pkg::MAX_PARTICLES)
    ) u_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    psu_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .elapsed(div_elapsed),
        .life   (mem_rdata.life),
        .done   (div_done),
        .factor (factor)
    );

    psu_blend u_blend (
        .ent   (ent_reg),
        .factor(factor),
        .color (bl_color),
        .size  (bl_size)
    );

    assign item_ready = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        logic [31:0]        tstart;
        logic [32:0]        end_time;
        logic signed [65:0] prod;
        logic signed [31:0] msel;
        state_next        = state_reg;
        ph_next           = ph_reg;
        idx_next          = idx_reg;
        live_next         = live_reg;
        cnt_next          = cnt_reg;
        origin_x_next     = origin_x_reg;
        origin_y_next     = origin_y_reg;
        prev_time_next    = prev_time_reg;
        seen_next         = seen_reg;
        tv_next           = tv_reg;
        dt_next           = dt_reg;
        arg_x_next        = arg_x_reg;
        arg_y_next        = arg_y_reg;
        ent_next          = ent_reg;
        mul_next          = mul_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        mem_we            = 1'b0;
        mem_waddr         = idx_reg[AW-1:0];
        mem_wdata         = ent_reg;
        mem_raddr         = idx_reg[AW-1:0];
        div_start         = 1'b0;
        div_elapsed       = (tv_reg >= mem_rdata.birth) ? tv_reg - mem_rdata.birth : 32'd0;
        tstart            = seen_reg ? prev_time_reg : item.time_value;
        end_time          = {1'b0, mem_rdata.birth} + {1'b0, mem_rdata.life};
        case (cnt_reg)
            3'd0:    msel = ent_reg.vx;
            3'd1:    msel = ent_reg.vy;
            3'd2:    msel = ent_reg.ax;
            default: msel = ent_reg.ay;
        endcase
        prod = $signed({msel[31], msel}) * $signed({1'b0, dt_reg});

        if (cfg_valid)
        begin
            if (cfg_index == psu_pkg::REG_ORIGIN_X)
            begin
                origin_x_next = cfg_data;
            end
            else if (cfg_index == psu_pkg::REG_ORIGIN_Y)
            begin
                origin_y_next = cfg_data;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    arg_x_next = item.arg_x;
                    arg_y_next = item.arg_y;
                    idx_next   = '0;
                    case (item.opcode)
                        psu_pkg::OP_ADD:
                        begin
                            if (live_reg < CW'(psu_pkg::MAX_PARTICLES))
                            begin
                                mem_we                = 1'b1;
                                mem_waddr             = live_reg[AW-1:0];
                                mem_wdata.x           = psu_pkg::sat_add32(origin_x_reg,
                                                            psu_pkg::sext48(item.arg_x));
                                mem_wdata.y           = psu_pkg::sat_add32(origin_y_reg,
                                                            psu_pkg::sext48(item.arg_y));
                                mem_wdata.vx          = item.vel_x;
                                mem_wdata.vy          = item.vel_y;
                                mem_wdata.ax          = item.acc_x;
                                mem_wdata.ay          = item.acc_y;
                                mem_wdata.begin_color = item.begin_color;
                                mem_wdata.end_color   = item.end_color;
                                mem_wdata.begin_size  = item.begin_size;
                                mem_wdata.end_size    = item.end_size;
                                mem_wdata.birth       = prev_time_reg;
                                mem_wdata.life        = item.time_value;
                                live_next             = live_reg + CW'(1);
                            end
                        end
                        psu_pkg::OP_TICK:
                        begin
                            tv_next        = item.time_value;
                            dt_next        = (item.time_value >= tstart)
                                           ? item.time_value - tstart : 32'd0;
                            prev_time_next = item.time_value;
                            seen_next      = 1'b1;
                            if (live_reg != '0)
                            begin
                                ph_next    = PH_MOVE;
                                state_next = S_RD;
                            end
                        end
                        psu_pkg::OP_SHIFT:
                        begin
                            if (live_reg != '0)
                            begin
                                ph_next    = PH_SHIFT;
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_LD;
            end
            S_LD:
            begin
                ent_next = mem_rdata;
                case (ph_reg)
                    PH_SHIFT:
                    begin
                        ent_next.x = psu_pkg::sat_add32(mem_rdata.x,
                                                        psu_pkg::sext48(arg_x_reg));
                        ent_next.y = psu_pkg::sat_add32(mem_rdata.y,
                                                        psu_pkg::sext48(arg_y_reg));
                        state_next = S_WR;
                    end
                    PH_MOVE:
                    begin
                        cnt_next   = 3'd0;
                        state_next = S_MUL;
                    end
                    PH_EXPIRE:
                    begin
                        if ({1'b0, tv_reg} > end_time)
                        begin
                            live_next = live_reg - CW'(1);
                            if (idx_reg + CW'(1) == live_reg)
                            begin
                                // expired entry was the last one
                                idx_next = '0;
                                if (live_reg == CW'(1))
                                begin
                                    state_next = S_IDLE;
                                end
                                else
                                begin
                                    ph_next    = PH_EMIT;
                                    state_next = S_RD;
                                end
                            end
                            else
                            begin
                                state_next = S_MVRD;
                            end
                        end
                        else if (idx_reg + CW'(1) < live_reg)
                        begin
                            idx_next   = idx_reg + CW'(1);
                            state_next = S_RD;
                        end
                        else
                        begin
                            idx_next   = '0;
                            ph_next    = PH_EMIT;
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                endcase
            end
            S_MUL:
            begin
                if (cnt_reg != 3'd4)
                begin
                    mul_next = prod[63:16];
                end
                case (cnt_reg)
                    3'd1:    ent_next.x  = psu_pkg::sat_add32(ent_reg.x, mul_reg);
                    3'd2:    ent_next.y  = psu_pkg::sat_add32(ent_reg.y, mul_reg);
                    3'd3:    ent_next.vx = psu_pkg::sat_add32(ent_reg.vx, mul_reg);
                    3'd4:    ent_next.vy = psu_pkg::sat_add32(ent_reg.vy, mul_reg);
                    default: ;
                endcase
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + CW'(1);
                if (idx_reg + CW'(1) < live_reg)
                begin
                    state_next = S_RD;
                end
                else if (ph_reg == PH_SHIFT)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = '0;
                    ph_next    = PH_EXPIRE;
                    state_next = S_RD;
                end
            end
            S_MVRD:
            begin
                mem_raddr  = live_reg[AW-1:0];
                state_next = S_MVWR;
            end
            S_MVWR:
            begin
                // move the last entry down, then check it at the same index
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                state_next = S_RD;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.out_x     = ent_reg.x;
                    result_next.out_y     = ent_reg.y;
                    result_next.out_size  = bl_size;
                    result_next.out_color = bl_color;
                    result_next.last      = (idx_reg + CW'(1) == live_reg);
                    result_valid_next     = 1'b1;
                    idx_next              = idx_reg + CW'(1);
                    state_next            = (idx_reg + CW'(1) < live_reg) ? S_RD : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ph_reg           <= PH_SHIFT;
            idx_reg          <= '0;
            live_reg         <= '0;
            cnt_reg          <= 3'd0;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            prev_time_reg    <= 32'd0;
            seen_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ph_reg           <= ph_next;
            idx_reg          <= idx_next;
            live_reg         <= live_next;
            cnt_reg          <= cnt_next;
            origin_x_reg     <= origin_x_next;
            origin_y_reg     <= origin_y_next;
            prev_time_reg    <= prev_time_next;
            seen_reg         <= seen_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tv_reg     <= tv_next;
        dt_reg     <= dt_next;
        arg_x_reg  <= arg_x_next;
        arg_y_reg  <= arg_y_next;
        ent_reg    <= ent_next;
        mul_reg    <= mul_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CW'(psu_pkg::MAX_PARTICLES))
        else $error("particle count above store depth");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.opcode == psu_pkg::OP_ADD
         && live_reg == CW'(psu_pkg::MAX_PARTICLES)) |=> $stable(live_reg))
        else $error("add accepted into a full store");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (idx_reg < live_reg))
        else $error("entry read beyond live particles");

endmodule
